// ===== src/vmag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vmag_pkg;

  // Store sizes
  localparam int unsigned VramDepth  = 65536;
  localparam int unsigned OamDepth   = 544;
  localparam int unsigned CgramDepth = 512;
  localparam int unsigned VramAw     = $clog2(VramDepth);
  localparam int unsigned OamAw      = $clog2(OamDepth);
  localparam int unsigned CgramAw    = $clog2(CgramDepth);

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVERSCAN  = 2'd0,
    CFG_INTERLACE = 2'd1,
    CFG_PAL       = 2'd2,
    CFG_REMAP     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TGT_VRAM  = 2'd0,
    TGT_OAM   = 2'd1,
    TGT_CGRAM = 2'd2,
    TGT_NONE  = 2'd3
  } target_e;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REMAP_DIRECT = 2'd0,
    REMAP_ROT8   = 2'd1,
    REMAP_ROT9   = 2'd2,
    REMAP_ROT10  = 2'd3
  } remap_e;

  // Beam timing
  localparam logic [8:0]  VisLinesNormal   = 9'd224;
  localparam logic [8:0]  VisLinesOverscan = 9'd239;
  localparam logic [8:0]  LastLineNtsc     = 9'((525 >> 1) - 1);
  localparam logic [8:0]  LastLinePal      = 9'((625 >> 1) - 1);
  localparam logic [10:0] HEdgeRead        = 11'd1362;
  localparam logic [10:0] HEdgeWriteLast   = 11'd4;
  localparam logic [10:0] HEdgeLatch       = 11'd6;
  localparam logic [9:0]  OamFoldMask      = 10'h21f;
  localparam logic [7:0]  CgramOddMask     = 8'h7f;

  typedef struct packed {
    logic        operation;
    logic [1:0]  target;
    logic [15:0] address;
    logic        byte_high;
    logic [7:0]  write_data;
    logic        display_off;
    logic [8:0]  vcount;
    logic [10:0] hcount;
    logic        odd_field;
    logic [7:0]  bus_latch;
    logic [9:0]  oam_internal_addr;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_done;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/vmag_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vmag_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/video_memory_access_gate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload  Transaction when
// req_i     in   req_t    req_i.valid && req_i.ready
// rsp_o     out  rsp_t    rsp_o.valid && rsp_o.ready
// cfg       in   2b/2b    cfg_we_i (no wait, no read-back)
//
// One transaction per cycle while rsp_o is not stalled; acceptance loads the decode
// register; moving on loads the registered memory read port and raises rsp_o.valid.
// After reset a clearing pass zeroes all three stores, one address per
// cycle, during which req_i.ready stays low.
// A stalled rsp_o holds the result stage; one more transaction may still
// be taken into the decode register.
module video_memory_access_gate
  import vmag_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  vmag_chan_if.sink            req_i,
  vmag_chan_if.source          rsp_o,
  input  wire                  cfg_we_i,
  input  wire  [CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [CfgDataW-1:0]  cfg_data_i
);

  typedef struct packed {
    logic [1:0]  tgt;
    logic        we;
    logic        zero;
    logic        mask7;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } dec_t;

  typedef struct packed {
    logic [1:0] tgt;
    logic       zero;
    logic       mask7;
    logic       done;
  } res_t;

  function automatic logic [OamAw-1:0] oam_fold(input logic [OamAw-1:0] a);
    oam_fold = a[OamAw-1] ? (a & OamFoldMask) : a;
  endfunction

  // Configuration registers
  logic       overscan_q, interlace_q, pal_q;
  logic [1:0] remap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overscan_q  <= 1'b0;
      interlace_q <= 1'b0;
      pal_q       <= 1'b0;
      remap_q     <= REMAP_DIRECT;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_OVERSCAN:  overscan_q  <= cfg_data_i[0];
        CFG_INTERLACE: interlace_q <= cfg_data_i[0];
        CFG_PAL:       pal_q       <= cfg_data_i[0];
        CFG_REMAP:     remap_q     <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Clearing pass after reset
  logic              clr_q;
  logic [VramAw-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (&clr_idx_q) clr_q <= 1'b0;
    end
  end

  // Pipeline handshake
  logic s1_valid_q, s2_valid_q;
  logic mv, in_acc, out_acc;

  assign mv          = s1_valid_q && (!s2_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_q && (!s1_valid_q || mv);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_acc     = s2_valid_q && rsp_o.ready;

  // Decode one transaction
  req_t              rq;
  dec_t              dec;
  logic [8:0]        vis, vis_p1, last_line;
  logic [15:0]       vaddr;
  logic              v_rd_zero, v_go, use_latch;
  logic [OamAw-1:0]  oaddr;
  logic [CgramAw-1:0] caddr;

  assign rq = req_i.payload;

  always_comb begin
    vis       = overscan_q ? VisLinesOverscan : VisLinesNormal;
    vis_p1    = vis + 9'd1;
    last_line = (pal_q ? LastLinePal : LastLineNtsc)
              + {8'd0, interlace_q && !rq.odd_field};

    // Remap word address, then form the byte address
    case (remap_e'(remap_q))
      REMAP_ROT8:  vaddr = {rq.address[15:8],  rq.address[4:0], rq.address[7:5]};
      REMAP_ROT9:  vaddr = {rq.address[15:9],  rq.address[5:0], rq.address[8:6]};
      REMAP_ROT10: vaddr = {rq.address[15:10], rq.address[6:0], rq.address[9:7]};
      default:     vaddr = rq.address;
    endcase

    // Beam gating of video RAM
    v_rd_zero = !rq.display_off &&
                ((rq.vcount == last_line && rq.hcount == HEdgeRead) ||
                 (rq.vcount < vis) ||
                 (rq.vcount == vis && rq.hcount != HEdgeRead));
    use_latch = !rq.display_off && rq.vcount == 9'd0 && rq.hcount == HEdgeLatch;
    if (rq.display_off) begin
      v_go = 1'b1;
    end else if (rq.vcount == 9'd0) begin
      v_go = (rq.hcount <= HEdgeWriteLast) || (rq.hcount == HEdgeLatch);
    end else if (rq.vcount < vis_p1) begin
      v_go = 1'b0;
    end else if (rq.vcount == vis_p1) begin
      v_go = rq.hcount > HEdgeWriteLast;
    end else begin
      v_go = 1'b1;
    end

    oaddr = (!rq.display_off && rq.vcount < vis_p1) ? oam_fold(rq.oam_internal_addr)
                                                    : oam_fold(rq.address[OamAw-1:0]);
    caddr = rq.address[CgramAw-1:0];

    dec       = '0;
    dec.tgt   = rq.target;
    dec.wdata = rq.write_data;
    case (target_e'(rq.target))
      TGT_VRAM: begin
        dec.addr  = {vaddr[14:0], rq.byte_high};
        if (rq.operation == OP_WRITE) begin
          dec.we    = v_go;
          dec.zero  = 1'b1;
          dec.wdata = use_latch ? rq.bus_latch : rq.write_data;
        end else begin
          dec.zero  = v_rd_zero;
        end
      end
      TGT_OAM: begin
        dec.addr = {{(16-OamAw){1'b0}}, oaddr};
        dec.we   = rq.operation == OP_WRITE;
        dec.zero = rq.operation == OP_WRITE;
      end
      TGT_CGRAM: begin
        dec.addr  = {{(16-CgramAw){1'b0}}, caddr};
        dec.we    = rq.operation == OP_WRITE;
        dec.zero  = rq.operation == OP_WRITE;
        dec.mask7 = caddr[0];
        if (caddr[0]) dec.wdata = rq.write_data & CgramOddMask;
      end
      default: begin
        dec.zero = 1'b1;
      end
    endcase
  end

  // Decode register
  dec_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (mv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= dec;
  end

  // Result stage control
  res_t s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (mv) begin
      s2_valid_q <= 1'b1;
    end else if (out_acc) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      s2_q.tgt   <= s1_q.tgt;
      s2_q.zero  <= s1_q.zero;
      s2_q.mask7 <= s1_q.mask7;
      s2_q.done  <= s1_q.we;
    end
  end

  // Store port controls (clearing pass owns the write port)
  logic               sel_v, sel_o, sel_c;
  logic               vram_we, oam_we, cg_we;
  logic               vram_re, oam_re, cg_re;
  logic [VramAw-1:0]  vram_wa;
  logic [OamAw-1:0]   oam_wa;
  logic [CgramAw-1:0] cg_wa;
  logic [7:0]         mem_wd;

  assign sel_v   = mv && s1_q.tgt == TGT_VRAM;
  assign sel_o   = mv && s1_q.tgt == TGT_OAM;
  assign sel_c   = mv && s1_q.tgt == TGT_CGRAM;
  assign vram_we = clr_q || (sel_v && s1_q.we);
  assign oam_we  = (clr_q && clr_idx_q < VramAw'(OamDepth)) || (sel_o && s1_q.we);
  assign cg_we   = (clr_q && clr_idx_q < VramAw'(CgramDepth)) || (sel_c && s1_q.we);
  assign vram_re = sel_v && !s1_q.we;
  assign oam_re  = sel_o && !s1_q.we;
  assign cg_re   = sel_c && !s1_q.we;
  assign vram_wa = clr_q ? clr_idx_q : s1_q.addr[VramAw-1:0];
  assign oam_wa  = clr_q ? clr_idx_q[OamAw-1:0] : s1_q.addr[OamAw-1:0];
  assign cg_wa   = clr_q ? clr_idx_q[CgramAw-1:0] : s1_q.addr[CgramAw-1:0];
  assign mem_wd  = clr_q ? 8'd0 : s1_q.wdata;

  // Video RAM
  logic [7:0] vram_mem [VramDepth];
  logic [7:0] vram_rd_q;

  always_ff @(posedge clk_i) begin
    if (vram_we) vram_mem[vram_wa] <= mem_wd;
    if (vram_re) vram_rd_q <= vram_mem[s1_q.addr[VramAw-1:0]];
  end

  // Sprite attribute RAM
  logic [7:0] oam_mem [OamDepth];
  logic [7:0] oam_rd_q;

  always_ff @(posedge clk_i) begin
    if (oam_we) oam_mem[oam_wa] <= mem_wd;
    if (oam_re) oam_rd_q <= oam_mem[s1_q.addr[OamAw-1:0]];
  end

  // Palette RAM
  logic [7:0] cg_mem [CgramDepth];
  logic [7:0] cg_rd_q;

  always_ff @(posedge clk_i) begin
    if (cg_we) cg_mem[cg_wa] <= mem_wd;
    if (cg_re) cg_rd_q <= cg_mem[s1_q.addr[CgramAw-1:0]];
  end

  // Drive the result
  logic [7:0] rd_sel;
  rsp_t       rsp;

  always_comb begin
    case (target_e'(s2_q.tgt))
      TGT_VRAM:  rd_sel = vram_rd_q;
      TGT_OAM:   rd_sel = oam_rd_q;
      TGT_CGRAM: rd_sel = cg_rd_q;
      default:   rd_sel = 8'd0;
    endcase
    rsp.read_data  = s2_q.zero ? 8'd0 : (s2_q.mask7 ? (rd_sel & CgramOddMask) : rd_sel);
    rsp.write_done = s2_q.done;
  end

  assign rsp_o.valid   = s2_valid_q;
  assign rsp_o.payload = rsp;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !req_i.ready)
    else $error("transaction accepted during clearing pass");

  a_clear_runs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> $past(clr_idx_q) == {VramAw{1'b1}})
    else $error("clearing pass ended early");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !rsp_o.ready) |-> !mv)
    else $error("decode stage advanced into a stalled result stage");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.done) |-> rsp.read_data == 8'd0)
    else $error("write transaction returned nonzero read data");

  a_no_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clr_q && !mv) |-> !(vram_we || oam_we || cg_we))
    else $error("store written without a transaction");

endmodule

`default_nettype wire

// ===== test/video_memory_access_gate_tb.sv =====
`timescale 1ns / 1ps

module video_memory_access_gate_tb;
  import vmag_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 56;
  localparam int unsigned NumPhases = 8;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  vmag_chan_if #(.payload_t(req_t)) req_if ();
  vmag_chan_if #(.payload_t(rsp_t)) rsp_if ();

  video_memory_access_gate dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copies of the three stores and the configuration
  logic [7:0] vram_shadow [VramDepth];
  logic [7:0] oam_shadow [OamDepth];
  logic [7:0] cgram_shadow [CgramDepth];
  logic cur_overscan;
  logic cur_interlace;
  logic cur_pal;
  remap_e cur_remap;

  req_t access_q [$];
  rsp_t predicted_rsp_q [$];

  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  logic req_taken;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_reads;
  int unsigned n_writes;
  int unsigned n_landed;

  // Fold an OAM address into the 544-byte store
  function automatic logic [9:0] oam_fold(input logic [9:0] a);
    return a[9] ? (a & OamFoldMask) : a;
  endfunction

  // Predict the result of one access and update the shadow stores
  function automatic rsp_t predict_access(input req_t r);
    rsp_t res;
    logic [15:0] w;
    logic [15:0] ba;
    logic [8:0] vis;
    logic [8:0] last;
    logic go;
    logic [7:0] val;
    logic [9:0] oa;
    logic [8:0] ca;
    res = '0;
    vis = cur_overscan ? VisLinesOverscan : VisLinesNormal;
    case (target_e'(r.target))
      TGT_VRAM: begin
        // Rotate the low address group left by three, then form the byte address
        w = r.address;
        case (cur_remap)
          REMAP_ROT8:  w = {w[15:8], w[4:0], w[7:5]};
          REMAP_ROT9:  w = {w[15:9], w[5:0], w[8:6]};
          REMAP_ROT10: w = {w[15:10], w[6:0], w[9:7]};
          default: ;
        endcase
        ba = {w[14:0], r.byte_high};
        if (op_e'(r.operation) == OP_READ) begin
          last = cur_pal ? LastLinePal : LastLineNtsc;
          if (cur_interlace && !r.odd_field) last = last + 9'd1;
          if (r.display_off) res.read_data = vram_shadow[ba];
          else if (r.vcount == last && r.hcount == HEdgeRead) res.read_data = '0;
          else if (r.vcount < vis) res.read_data = '0;
          else if (r.vcount == vis)
            res.read_data = (r.hcount == HEdgeRead) ? vram_shadow[ba] : 8'h00;
          else res.read_data = vram_shadow[ba];
        end else begin
          go = 1'b0;
          val = r.write_data;
          if (r.display_off) begin
            go = 1'b1;
          end else if (r.vcount == 9'd0) begin
            if (r.hcount <= HEdgeWriteLast) begin
              go = 1'b1;
            end else if (r.hcount == HEdgeLatch) begin
              go = 1'b1;
              val = r.bus_latch;
            end
          end else if (r.vcount <= vis) begin
            go = 1'b0;
          end else if (r.vcount == vis + 9'd1) begin
            go = r.hcount > HEdgeWriteLast;
          end else begin
            go = 1'b1;
          end
          if (go) begin
            vram_shadow[ba] = val;
            res.write_done = 1'b1;
          end
        end
      end
      TGT_OAM: begin
        // Active lines use the internal address
        oa = oam_fold(r.address[9:0]);
        if (!r.display_off && r.vcount <= vis) oa = oam_fold(r.oam_internal_addr);
        if (op_e'(r.operation) == OP_READ) begin
          res.read_data = oam_shadow[oa];
        end else begin
          oam_shadow[oa] = r.write_data;
          res.write_done = 1'b1;
        end
      end
      TGT_CGRAM: begin
        // Mask odd palette bytes to seven bits
        ca = r.address[8:0];
        if (op_e'(r.operation) == OP_READ) begin
          res.read_data = ca[0] ? (cgram_shadow[ca] & CgramOddMask) : cgram_shadow[ca];
        end else begin
          cgram_shadow[ca] = ca[0] ? (r.write_data & CgramOddMask) : r.write_data;
          res.write_done = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Build a random access biased toward beam edges and a small address pool
  function automatic req_t random_access();
    req_t r;
    logic [8:0] vis;
    logic [8:0] last;
    r.operation = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
    if ($urandom_range(0, 19) == 0) begin
      r.target = TGT_NONE;
    end else begin
      case ($urandom_range(0, 2))
        0: r.target = TGT_VRAM;
        1: r.target = TGT_OAM;
        default: r.target = TGT_CGRAM;
      endcase
    end
    if ($urandom_range(0, 9) < 6)
      r.address = {($urandom_range(0, 1) != 0) ? 6'h3f : 6'h00,
                   10'($urandom_range(0, 7) * 'h49)};
    else
      r.address = 16'($urandom());
    r.byte_high = 1'($urandom_range(0, 1));
    r.write_data = 8'($urandom_range(0, 255));
    r.display_off = ($urandom_range(0, 9) < 4);
    vis = cur_overscan ? VisLinesOverscan : VisLinesNormal;
    last = cur_pal ? LastLinePal : LastLineNtsc;
    case ($urandom_range(0, 9))
      0: r.vcount = 9'd0;
      1: r.vcount = vis - 9'd1;
      2: r.vcount = vis;
      3: r.vcount = vis + 9'd1;
      4: r.vcount = vis + 9'd2;
      5: r.vcount = last;
      6: r.vcount = last + 9'd1;
      default: r.vcount = 9'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 7))
      0: r.hcount = 11'($urandom_range(0, 6));
      1: r.hcount = HEdgeRead;
      2: r.hcount = ($urandom_range(0, 1) != 0) ? HEdgeRead + 11'd1 : HEdgeRead - 11'd1;
      3: r.hcount = 11'd1364;
      default: r.hcount = 11'($urandom_range(0, 1364));
    endcase
    r.odd_field = 1'($urandom_range(0, 1));
    r.bus_latch = 8'($urandom_range(0, 255));
    r.oam_internal_addr = ($urandom_range(0, 9) < 3) ? 10'($urandom_range(512, 543))
                                                     : 10'($urandom_range(0, 511));
    return r;
  endfunction

  task automatic add_access(input op_e op, input target_e tgt, input logic [15:0] addr,
                            input logic hi, input logic [7:0] data, input logic doff,
                            input logic [8:0] v, input logic [10:0] h, input logic odd,
                            input logic [7:0] latch, input logic [9:0] iaddr);
    req_t r;
    r.operation = op;
    r.target = tgt;
    r.address = addr;
    r.byte_high = hi;
    r.write_data = data;
    r.display_off = doff;
    r.vcount = v;
    r.hcount = h;
    r.odd_field = odd;
    r.bus_latch = latch;
    r.oam_internal_addr = iaddr;
    access_q.push_back(r);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_OVERSCAN:  cur_overscan = val[0];
      CFG_INTERLACE: cur_interlace = val[0];
      CFG_PAL:       cur_pal = val[0];
      default:       cur_remap = remap_e'(val);
    endcase
  endtask

  task automatic apply_setting(input logic ov, input logic il, input logic pal,
                               input remap_e remap);
    write_cfg(CFG_OVERSCAN, {1'b0, ov});
    write_cfg(CFG_INTERLACE, {1'b0, il});
    write_cfg(CFG_PAL, {1'b0, pal});
    write_cfg(CFG_REMAP, remap);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold off until every queued access has been taken and answered
  task automatic drain();
    while (access_q.size() != 0 || req_if.valid || predicted_rsp_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected read_data=%02h write_done=%0d, got read_data=%02h write_done=%0d",
               $time, what, want.read_data, want.write_done, got.read_data, got.write_done);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive the request channel and the response back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_if.payload <= access_q.pop_front();
          req_if.valid <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // Check results and predict each accepted transaction
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, predicted_rsp_q.size());
      $display("video_memory_access_gate verification failed");
      $finish;
    end
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (predicted_rsp_q.size() == 0) begin
          note_failure("result with no transaction pending", got, got);
        end else begin
          want = predicted_rsp_q.pop_front();
          n_checked++;
          if (got.write_done === 1'b1) n_landed++;
          if (got.read_data !== want.read_data || got.write_done !== want.write_done)
            note_failure("result mismatch", want, got);
        end
      end
      if (req_if.valid && req_if.ready) begin
        n_accepted++;
        if (op_e'(req_if.payload.operation) == OP_WRITE) n_writes++;
        else n_reads++;
        predicted_rsp_q.push_back(predict_access(req_if.payload));
      end
      req_taken <= req_if.valid && req_if.ready;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OVERSCAN;
    cfg_data_i = '0;
    req_taken = 1'b0;
    rst_ni = 1'b0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    cycle_count = 0;
    fail_count = 0;
    n_accepted = 0;
    n_checked = 0;
    n_reads = 0;
    n_writes = 0;
    n_landed = 0;
    cur_overscan = 1'b0;
    cur_interlace = 1'b0;
    cur_pal = 1'b0;
    cur_remap = REMAP_DIRECT;
    foreach (vram_shadow[i]) vram_shadow[i] = '0;
    foreach (oam_shadow[i]) oam_shadow[i] = '0;
    foreach (cgram_shadow[i]) cgram_shadow[i] = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed accesses under the reset configuration
    add_access(OP_WRITE, TGT_VRAM, 16'h0000, 1'b0, 8'ha5, 1'b1, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0);
    add_access(OP_READ, TGT_VRAM, 16'h0000, 1'b0, 8'h00, 1'b1, 9'd100, 11'd9, 1'b0, 8'h00, 10'd0);
    add_access(OP_WRITE, TGT_VRAM, 16'hffff, 1'b1, 8'hff, 1'b1, 9'd511, 11'd1364, 1'b1, 8'hff,
               10'd543);
    // last line of the frame at the read edge
    add_access(OP_READ, TGT_VRAM, 16'hffff, 1'b1, 8'h00, 1'b0, LastLineNtsc, HEdgeRead, 1'b0,
               8'h00, 10'd0);
    add_access(OP_READ, TGT_VRAM, 16'hffff, 1'b1, 8'h00, 1'b0, LastLineNtsc, 11'd1361, 1'b0,
               8'h00, 10'd0);
    // first blank line: only the read edge reaches memory
    add_access(OP_READ, TGT_VRAM, 16'h0000, 1'b0, 8'h00, 1'b0, 9'd224, HEdgeRead, 1'b1, 8'h00,
               10'd0);
    add_access(OP_READ, TGT_VRAM, 16'h0000, 1'b0, 8'h00, 1'b0, 9'd224, 11'd0, 1'b1, 8'h00, 10'd0);
    add_access(OP_READ, TGT_VRAM, 16'h0000, 1'b0, 8'h00, 1'b0, 9'd100, 11'd500, 1'b0, 8'h00,
               10'd0);
    // line zero write window and the bus latch cycle
    add_access(OP_WRITE, TGT_VRAM, 16'h0010, 1'b0, 8'h11, 1'b0, 9'd0, 11'd0, 1'b0, 8'hee, 10'd0);
    add_access(OP_WRITE, TGT_VRAM, 16'h0011, 1'b0, 8'h22, 1'b0, 9'd0, 11'd4, 1'b0, 8'hee, 10'd0);
    add_access(OP_WRITE, TGT_VRAM, 16'h0012, 1'b0, 8'h99, 1'b0, 9'd0, 11'd5, 1'b0, 8'hee, 10'd0);
    add_access(OP_WRITE, TGT_VRAM, 16'h0013, 1'b0, 8'h33, 1'b0, 9'd0, 11'd6, 1'b0, 8'h5a, 10'd0);
    // line after the visible count
    add_access(OP_WRITE, TGT_VRAM, 16'h0014, 1'b0, 8'h66, 1'b0, 9'd225, 11'd4, 1'b0, 8'h00, 10'd0);
    add_access(OP_WRITE, TGT_VRAM, 16'h0015, 1'b0, 8'h44, 1'b0, 9'd225, 11'd5, 1'b0, 8'h00, 10'd0);
    add_access(OP_WRITE, TGT_VRAM, 16'h0016, 1'b0, 8'h55, 1'b0, 9'd120, 11'd800, 1'b0, 8'h00,
               10'd0);
    add_access(OP_READ, TGT_VRAM, 16'h0013, 1'b0, 8'h00, 1'b1, 9'd0, 11'd0, 1'b0, 8'h00, 10'd0);
    // unused target
    add_access(OP_WRITE, TGT_NONE, 16'h1234, 1'b1, 8'hc3, 1'b1, 9'd300, 11'd10, 1'b0, 8'h00,
               10'd0);
    add_access(OP_READ, TGT_NONE, 16'h1234, 1'b0, 8'h00, 1'b1, 9'd300, 11'd10, 1'b0, 8'h00, 10'd0);
    // sprite address fold, direct and internal
    add_access(OP_WRITE, TGT_OAM, 16'h03ff, 1'b0, 8'h77, 1'b1, 9'd10, 11'd10, 1'b0, 8'h00, 10'd0);
    add_access(OP_READ, TGT_OAM, 16'h0000, 1'b0, 8'h00, 1'b0, 9'd10, 11'd10, 1'b0, 8'h00, 10'd543);
    add_access(OP_WRITE, TGT_OAM, 16'hfe00, 1'b0, 8'h3c, 1'b0, 9'd300, 11'd10, 1'b0, 8'h00,
               10'd5);
    // palette odd byte masking
    add_access(OP_WRITE, TGT_CGRAM, 16'h0001, 1'b0, 8'hff, 1'b0, 9'd50, 11'd10, 1'b0, 8'h00, 10'd0);
    add_access(OP_READ, TGT_CGRAM, 16'hfe01, 1'b0, 8'h00, 1'b0, 9'd50, 11'd10, 1'b0, 8'h00, 10'd0);
    add_access(OP_WRITE, TGT_CGRAM, 16'h01fe, 1'b0, 8'h80, 1'b0, 9'd50, 11'd10, 1'b0, 8'h00, 10'd0);
    add_access(OP_READ, TGT_CGRAM, 16'h01fe, 1'b0, 8'h00, 1'b0, 9'd50, 11'd10, 1'b0, 8'h00, 10'd0);
    drain();

    // Random phases, each under its own setting and idling mix
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_setting(1'b0, 1'b0, 1'b0, REMAP_DIRECT);
        1: apply_setting(1'b1, 1'b1, 1'b1, REMAP_ROT10);
        2: apply_setting(1'b1, 1'b0, 1'b0, REMAP_ROT8);
        3: apply_setting(1'b0, 1'b1, 1'b0, REMAP_ROT9);
        4: apply_setting(1'b0, 1'b0, 1'b1, REMAP_ROT10);
        5: apply_setting(1'b1, 1'b1, 1'b0, REMAP_DIRECT);
        6: apply_setting(1'b0, 1'b1, 1'b1, REMAP_ROT8);
        default: apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), remap_e'($urandom_range(0, 3)));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
        default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) access_q.push_back(random_access());
      drain();
    end

    fail_count += predicted_rsp_q.size();
    $display("%0d transactions checked over %0d settings: %0d reads, %0d writes, %0d stored",
             n_checked, NumPhases + 1, n_reads, n_writes, n_landed);
    $display("%0d of %0d accepted transactions answered, %0d failures",
             n_checked, n_accepted, fail_count);
    if (fail_count == 0) begin
      $display("video_memory_access_gate verification clean");
    end else begin
      $display("video_memory_access_gate verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vmag_pkg.sv
src/vmag_chan_if.sv
src/video_memory_access_gate.sv
test/video_memory_access_gate_tb.sv
